### design/escape_time_fractal_iterator_assert.svh
// Assertion macros for the escape time fractal iterator checker
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define ETF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("etf assertion failed");

// Next-cycle implication, disabled while reset is held
`define ETF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("etf assertion failed");

`endif

### design/etf_pkg.sv
// Shared types, constants and helpers of the escape time fractal iterator
package etf_pkg;

    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 26;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int LIMIT_BITS    = 16;
    localparam int STEP_BITS     = 31;
    localparam int MAP_BITS      = COORD_BITS + STEP_BITS;

    localparam logic [CFG_ADDR_BITS-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LIMIT    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_R = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_I = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_R   = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_I   = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_JULIA_R  = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_JULIA_I  = 3'd7;

    localparam logic [63:0] ORIGIN_RESET64 = ~(64'd2 << FRAC_BITS) + 64'd1;
    localparam logic [63:0] STEP_RESET64   = 64'd1 << (FRAC_BITS - 8);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd64;
    localparam logic [63:0] ESC_BOUND      = 64'd4 << FRAC_BITS;

    typedef enum logic [1:0] {
        MODE_MANDELBROT = 2'd0,
        MODE_MANDELBAR  = 2'd1,
        MODE_JULIA      = 2'd2,
        MODE_BURNING    = 2'd3
    } t_mode;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_BITS-1:0] iteration_count;
        logic                  reached_limit;
    } t_out_beat;

    typedef struct packed {
        t_mode                  mode;
        logic [LIMIT_BITS-1:0]  iteration_limit;
        logic signed [31:0]     origin_re;
        logic signed [31:0]     origin_im;
        logic [STEP_BITS-1:0]   step_re;
        logic [STEP_BITS-1:0]   step_im;
        logic signed [31:0]     julia_re;
        logic signed [31:0]     julia_im;
    } t_cfg;

    typedef struct packed {
        logic load_px;
        logic map;
        logic init;
        logic mul;
        logic upd;
    } t_dp_cmd;

    typedef struct packed {
        logic limit_zero;
        logic escape;
        logic last;
    } t_dp_sts;

    // Clamp the programmed limit to what the counter can hold
    function automatic logic [COUNT_BITS-1:0] sat_limit(input logic [LIMIT_BITS-1:0] lim);
        logic [31:0] l32;
        logic [31:0] m32;
        l32 = 32'(lim);
        m32 = (32'd1 << COUNT_BITS) - 32'd1;
        if (l32 > m32) begin
            return m32[COUNT_BITS-1:0];
        end
        return l32[COUNT_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

### design/etf_ctrl.sv
// Sequencer of the escape time fractal iterator
module etf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_out_free,
    output logic             o_out_load,
    output etf_pkg::t_dp_cmd o_cmd,
    input  etf_pkg::t_dp_sts i_sts
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAP  = 6'b000010,
        S_INIT = 6'b000100,
        S_MUL  = 6'b001000,
        S_UPD  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_out_load = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_px = 1'b1;
                    n_state       = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = S_INIT;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = i_sts.limit_zero ? S_DONE : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                // escape leaves z and the count as they are
                if (i_sts.escape) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.upd = 1'b1;
                    n_state   = i_sts.last ? S_DONE : S_MUL;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/etf_dp.sv
// Datapath: pixel mapping, complex squaring, escape test and counter
module etf_dp (
    input  logic                i_clk,
    input  etf_pkg::t_cfg       i_cfg,
    input  etf_pkg::t_in_beat   i_in,
    input  etf_pkg::t_dp_cmd    i_cmd,
    output etf_pkg::t_dp_sts    o_sts,
    output etf_pkg::t_out_beat  o_result
);

    logic [etf_pkg::COORD_BITS-1:0] r_px;
    logic [etf_pkg::COORD_BITS-1:0] r_py;
    logic [etf_pkg::MAP_BITS-1:0]   r_map_re;
    logic [etf_pkg::MAP_BITS-1:0]   r_map_im;
    logic signed [31:0]             r_z_re;
    logic signed [31:0]             r_z_im;
    logic signed [31:0]             r_c_re;
    logic signed [31:0]             r_c_im;
    logic signed [63:0]             r_rr;
    logic signed [63:0]             r_ii;
    logic signed [63:0]             r_ri;
    logic [etf_pkg::COUNT_BITS-1:0] r_n;

    logic [etf_pkg::COUNT_BITS-1:0] limit_eff;
    logic signed [31:0]             pt_re;
    logic signed [31:0]             pt_im;
    logic [63:0]                    mag_sum;
    logic signed [64:0]             diff;
    logic signed [64:0]             nr0;
    logic signed [64:0]             ri_sel;
    logic signed [64:0]             ni0;
    logic signed [31:0]             nr;
    logic signed [31:0]             ni;

    assign limit_eff = etf_pkg::sat_limit(i_cfg.iteration_limit);

    assign pt_re = etf_pkg::sat32(66'(i_cfg.origin_re) + $signed({2'b00, r_map_re}));
    assign pt_im = etf_pkg::sat32(66'(i_cfg.origin_im) + $signed({2'b00, r_map_im}));

    assign mag_sum = ($unsigned(r_rr) >> etf_pkg::FRAC_BITS)
                   + ($unsigned(r_ii) >> etf_pkg::FRAC_BITS);

    assign diff = 65'(r_rr) - 65'(r_ii);
    assign nr0  = diff >>> etf_pkg::FRAC_BITS;

    // mandelbar flips the sign of the cross term, burning ship takes its magnitude
    always_comb begin
        case (i_cfg.mode)
            etf_pkg::MODE_MANDELBAR: ri_sel = -65'(r_ri);
            etf_pkg::MODE_BURNING:   ri_sel = r_ri[63] ? -65'(r_ri) : 65'(r_ri);
            default:                 ri_sel = 65'(r_ri);
        endcase
    end

    assign ni0 = ri_sel >>> (etf_pkg::FRAC_BITS - 1);
    assign nr  = (i_cfg.mode == etf_pkg::MODE_BURNING)
               ? etf_pkg::sat32(66'(nr0) - 66'(r_c_re))
               : etf_pkg::sat32(66'(nr0) + 66'(r_c_re));
    assign ni  = etf_pkg::sat32(66'(ni0) + 66'(r_c_im));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_px) begin
            r_px <= i_in.pixel_x;
            r_py <= i_in.pixel_y;
        end
        if (i_cmd.map) begin
            r_map_re <= etf_pkg::MAP_BITS'(r_px) * etf_pkg::MAP_BITS'(i_cfg.step_re);
            r_map_im <= etf_pkg::MAP_BITS'(r_py) * etf_pkg::MAP_BITS'(i_cfg.step_im);
        end
        if (i_cmd.init) begin
            r_n <= '0;
            if (i_cfg.mode == etf_pkg::MODE_JULIA) begin
                r_z_re <= pt_re;
                r_z_im <= pt_im;
                r_c_re <= i_cfg.julia_re;
                r_c_im <= i_cfg.julia_im;
            end else begin
                r_z_re <= '0;
                r_z_im <= '0;
                r_c_re <= pt_re;
                r_c_im <= pt_im;
            end
        end
        if (i_cmd.mul) begin
            r_rr <= r_z_re * r_z_re;
            r_ii <= r_z_im * r_z_im;
            r_ri <= r_z_re * r_z_im;
        end
        if (i_cmd.upd) begin
            r_z_re <= nr;
            r_z_im <= ni;
            r_n    <= r_n + etf_pkg::COUNT_BITS'(1);
        end
    end

    assign o_sts.limit_zero = (limit_eff == '0);
    assign o_sts.escape     = (mag_sum >= etf_pkg::ESC_BOUND);
    assign o_sts.last       = (r_n == limit_eff - etf_pkg::COUNT_BITS'(1));

    assign o_result.iteration_count = r_n;
    assign o_result.reached_limit   = (r_n == limit_eff);

endmodule

### design/escape_time_fractal_iterator.sv
// Top level: one pixel in, one iteration count out, computed in squaring rounds.
// The number of rounds is the reported count, plus one when the point escapes before the limit;
// each round runs the three squaring multipliers, then the escape test and update.
// The next pixel is taken only after the last one's count is loaded into the result register,
// which lets it start while a finished count still waits. A zero limit skips the squaring rounds.
// Synchronous active-low reset returns the sequencer to idle, drops the result and loads
// the register defaults (mandelbrot, limit 64, origin -2-2i, step 1/256).
module escape_time_fractal_iterator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  etf_pkg::t_in_beat                    i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output etf_pkg::t_out_beat                   o_out,
    input  logic                                 i_cfg_we,
    input  logic [etf_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  logic [etf_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);

    etf_pkg::t_cfg      r_cfg;
    etf_pkg::t_out_beat r_out;
    logic               r_out_valid;
    etf_pkg::t_dp_cmd   cmd;
    etf_pkg::t_dp_sts   sts;
    etf_pkg::t_out_beat result;
    logic               out_load;
    logic               out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= etf_pkg::MODE_MANDELBROT;
            r_cfg.iteration_limit <= etf_pkg::LIMIT_RESET;
            r_cfg.origin_re       <= etf_pkg::ORIGIN_RESET64[31:0];
            r_cfg.origin_im       <= etf_pkg::ORIGIN_RESET64[31:0];
            r_cfg.step_re         <= etf_pkg::STEP_RESET64[etf_pkg::STEP_BITS-1:0];
            r_cfg.step_im         <= etf_pkg::STEP_RESET64[etf_pkg::STEP_BITS-1:0];
            r_cfg.julia_re        <= '0;
            r_cfg.julia_im        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                etf_pkg::REG_MODE:     r_cfg.mode <= etf_pkg::t_mode'(i_cfg_wdata[1:0]);
                etf_pkg::REG_LIMIT:    r_cfg.iteration_limit <=
                                           i_cfg_wdata[etf_pkg::LIMIT_BITS-1:0];
                etf_pkg::REG_ORIGIN_R: r_cfg.origin_re <= i_cfg_wdata;
                etf_pkg::REG_ORIGIN_I: r_cfg.origin_im <= i_cfg_wdata;
                etf_pkg::REG_STEP_R:   r_cfg.step_re <= i_cfg_wdata[etf_pkg::STEP_BITS-1:0];
                etf_pkg::REG_STEP_I:   r_cfg.step_im <= i_cfg_wdata[etf_pkg::STEP_BITS-1:0];
                etf_pkg::REG_JULIA_R:  r_cfg.julia_re <= i_cfg_wdata;
                etf_pkg::REG_JULIA_I:  r_cfg.julia_im <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // hold the result beat until the sink takes it
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    etf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .o_out_load (out_load),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    etf_dp u_dp (
        .i_clk    (i_clk),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### design/etf_checker.sv
// Port-level checker for the escape time fractal iterator, bound to the top level
`include "escape_time_fractal_iterator_assert.svh"

module etf_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_stall,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  etf_pkg::t_out_beat                   o_out,
    input  logic                                 i_cfg_we,
    input  logic [etf_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  logic [etf_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);

    logic [etf_pkg::LIMIT_BITS-1:0] r_limit;
    logic [etf_pkg::COUNT_BITS-1:0] lim_eff;
    logic                           in_beat;

    // track the programmed limit from the write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= etf_pkg::LIMIT_RESET;
        end else if (i_cfg_we && i_cfg_addr == etf_pkg::REG_LIMIT) begin
            r_limit <= i_cfg_wdata[etf_pkg::LIMIT_BITS-1:0];
        end
    end

    assign lim_eff = etf_pkg::sat_limit(r_limit);
    assign in_beat = i_in_valid && !o_in_stall;

    `ETF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `ETF_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out))
    `ETF_ASSERT_NEXT(a_one_at_a_time, in_beat, o_in_stall)
    `ETF_ASSERT_IMPL(a_count_bound, o_out_valid, o_out.iteration_count <= lim_eff)
    `ETF_ASSERT_IMPL(a_limit_flag, o_out_valid,
                     o_out.reached_limit == (o_out.iteration_count == lim_eff))

endmodule

bind escape_time_fractal_iterator etf_checker u_etf_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the escape time fractal iterator: directed and random pixels
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 600000;
    localparam int TAIL_CYCLES    = 20;
    localparam int REPORT_LIMIT   = 10;
    localparam int FX_ONE         = 1 << etf_pkg::FRAC_BITS;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_stall;
    etf_pkg::t_in_beat                 i_in        = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    etf_pkg::t_out_beat                o_out;
    logic                              i_cfg_we    = 1'b0;
    logic [etf_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr  = '0;
    logic [etf_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata = '0;

    // Copy of the programmed window, starts at the reset defaults
    etf_pkg::t_mode                 view_mode    = etf_pkg::MODE_MANDELBROT;
    logic [etf_pkg::LIMIT_BITS-1:0] view_limit   = etf_pkg::LIMIT_RESET;
    logic signed [31:0]             view_org_re  = etf_pkg::ORIGIN_RESET64[31:0];
    logic signed [31:0]             view_org_im  = etf_pkg::ORIGIN_RESET64[31:0];
    logic [etf_pkg::STEP_BITS-1:0]  view_step_re =
        etf_pkg::STEP_RESET64[etf_pkg::STEP_BITS-1:0];
    logic [etf_pkg::STEP_BITS-1:0]  view_step_im =
        etf_pkg::STEP_RESET64[etf_pkg::STEP_BITS-1:0];
    logic signed [31:0]             seed_re      = '0;
    logic signed [31:0]             seed_im      = '0;

    etf_pkg::t_out_beat pending_counts[$];
    int                 mismatch_count     = 0;
    int                 quiet_cycles       = 0;
    int                 sender_idle_pct    = 0;
    int                 receiver_stall_pct = 0;

    escape_time_fractal_iterator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > S32_MAX) begin
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            return S32_MIN;
        end
        return v;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // Iterate the current window's map for one pixel and return the count it should report
    function automatic etf_pkg::t_out_beat escape_count(input etf_pkg::t_in_beat pix);
        logic signed [63:0] px, py, sx, sy, org_r, org_i;
        logic signed [63:0] pt_re, pt_im, cr, ci, zr, zi, nr, ni, twin;
        logic [63:0]        ar, ai, r2, i2;
        int                 n;
        int                 lim;
        bit                 escaped;
        etf_pkg::t_out_beat res;
        px    = pix.pixel_x;
        py    = pix.pixel_y;
        sx    = view_step_re;
        sy    = view_step_im;
        org_r = view_org_re;
        org_i = view_org_im;
        pt_re = clamp32(org_r + px * sx);
        pt_im = clamp32(org_i + py * sy);
        if (view_mode == etf_pkg::MODE_JULIA) begin
            zr = pt_re;
            zi = pt_im;
            cr = seed_re;
            ci = seed_im;
        end else begin
            zr = 0;
            zi = 0;
            cr = pt_re;
            ci = pt_im;
        end
        n       = 0;
        lim     = int'(view_limit);
        escaped = 1'b0;
        while (!escaped && n < lim) begin
            ar = magnitude(zr);
            ai = magnitude(zi);
            r2 = (ar * ar) >> etf_pkg::FRAC_BITS;
            i2 = (ai * ai) >> etf_pkg::FRAC_BITS;
            if (r2 + i2 >= etf_pkg::ESC_BOUND) begin
                escaped = 1'b1;
            end else begin
                if (view_mode == etf_pkg::MODE_MANDELBAR) begin
                    zi = -zi;
                end
                nr = (zr * zr - zi * zi) >>> etf_pkg::FRAC_BITS;
                if (view_mode == etf_pkg::MODE_BURNING) begin
                    twin = (ar * ai) >> (etf_pkg::FRAC_BITS - 1);
                    nr   = clamp32(nr - cr);
                    ni   = clamp32(twin + ci);
                end else begin
                    nr = clamp32(nr + cr);
                    ni = clamp32(((zi * zr) >>> (etf_pkg::FRAC_BITS - 1)) + ci);
                end
                zr = nr;
                zi = ni;
                n++;
            end
        end
        res.iteration_count = n[etf_pkg::COUNT_BITS-1:0];
        res.reached_limit   = (n == lim);
        return res;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge i_clk) begin : check_counts
        etf_pkg::t_out_beat want;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_counts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: result with nothing pending: count %0d limit %0b",
                             $time, o_out.iteration_count, o_out.reached_limit);
                end
            end else begin
                want = pending_counts.pop_front();
                if (o_out.iteration_count !== want.iteration_count ||
                    o_out.reached_limit !== want.reached_limit) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: expected count %0d limit %0b, got count %0d limit %0b",
                                 $time, want.iteration_count, want.reached_limit,
                                 o_out.iteration_count, o_out.reached_limit);
                    end
                end
            end
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drop valid and hold until every pending count has come back
    task automatic wait_for_counts();
        i_in_valid <= 1'b0;
        while (pending_counts.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_pixel(input logic [etf_pkg::COORD_BITS-1:0] x,
                              input logic [etf_pkg::COORD_BITS-1:0] y);
        etf_pkg::t_in_beat beat;
        beat.pixel_x = x;
        beat.pixel_y = y;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_counts.push_back(escape_count(beat));
    endtask

    task automatic put_reg(input logic [etf_pkg::CFG_ADDR_BITS-1:0] idx,
                           input logic [etf_pkg::CFG_DATA_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic program_window(input etf_pkg::t_mode m,
                                  input logic [etf_pkg::LIMIT_BITS-1:0] lim,
                                  input logic signed [31:0] ore,
                                  input logic signed [31:0] oim,
                                  input logic [etf_pkg::STEP_BITS-1:0] sre,
                                  input logic [etf_pkg::STEP_BITS-1:0] sim,
                                  input logic signed [31:0] jre,
                                  input logic signed [31:0] jim);
        wait_for_counts();
        put_reg(etf_pkg::REG_MODE, 32'(m));
        put_reg(etf_pkg::REG_LIMIT, 32'(lim));
        put_reg(etf_pkg::REG_ORIGIN_R, ore);
        put_reg(etf_pkg::REG_ORIGIN_I, oim);
        put_reg(etf_pkg::REG_STEP_R, 32'(sre));
        put_reg(etf_pkg::REG_STEP_I, 32'(sim));
        put_reg(etf_pkg::REG_JULIA_R, jre);
        put_reg(etf_pkg::REG_JULIA_I, jim);
        i_cfg_we     <= 1'b0;
        view_mode    = m;
        view_limit   = lim;
        view_org_re  = ore;
        view_org_im  = oim;
        view_step_re = sre;
        view_step_im = sim;
        seed_re      = jre;
        seed_im      = jim;
    endtask

    // Wide windows toggle every register bit; narrow ones stay near the set boundary
    task automatic random_window(input bit wide);
        etf_pkg::t_mode                 m;
        logic [etf_pkg::LIMIT_BITS-1:0] lim;
        logic signed [31:0]             ore, oim, jre, jim;
        logic [etf_pkg::STEP_BITS-1:0]  sre, sim;
        int                             pick;
        m    = etf_pkg::t_mode'(2'($urandom_range(3)));
        pick = $urandom_range(99);
        if (pick < 5) begin
            lim = '0;
        end else if (pick < 10) begin
            lim = etf_pkg::LIMIT_BITS'(1);
        end else if (pick < 20) begin
            lim = etf_pkg::LIMIT_BITS'($urandom_range(300, 100));
        end else begin
            lim = etf_pkg::LIMIT_BITS'($urandom_range(80, 2));
        end
        if (wide) begin
            ore = $urandom();
            oim = $urandom();
            sre = etf_pkg::STEP_BITS'($urandom());
            sim = etf_pkg::STEP_BITS'($urandom());
            jre = $urandom();
            jim = $urandom();
        end else begin
            ore = $urandom_range(3 * FX_ONE) - 2 * FX_ONE;
            oim = $urandom_range(3 * FX_ONE) - 2 * FX_ONE;
            sre = etf_pkg::STEP_BITS'($urandom_range(1 << 15, 1));
            sim = etf_pkg::STEP_BITS'($urandom_range(1 << 15, 1));
            jre = $urandom_range(2 * FX_ONE) - FX_ONE;
            jim = $urandom_range(2 * FX_ONE) - FX_ONE;
        end
        program_window(m, lim, ore, oim, sre, sim, jre, jim);
    endtask

    task automatic test_reset_window();
        send_pixel(12'd512, 12'd512);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd256, 12'd512);
        send_pixel(12'd4095, 12'd0);
    endtask

    task automatic test_special_cases();
        // zero limit: no iteration at all
        program_window(etf_pkg::MODE_MANDELBROT, 16'd0, -2 * FX_ONE, -2 * FX_ONE,
                       etf_pkg::STEP_RESET64[etf_pkg::STEP_BITS-1:0],
                       etf_pkg::STEP_RESET64[etf_pkg::STEP_BITS-1:0], '0, '0);
        send_pixel(12'd512, 12'd512);
        // c = 2: with limit 1 the first iteration reaches the limit; with limit 2 it escapes right after it
        program_window(etf_pkg::MODE_MANDELBROT, 16'd1, 2 * FX_ONE, '0, '0, '0, '0, '0);
        send_pixel(12'd4095, 12'd4095);
        program_window(etf_pkg::MODE_MANDELBROT, 16'd2, 2 * FX_ONE, '0, '0, '0, '0, '0);
        send_pixel(12'd7, 12'd9);
    endtask

    task automatic test_modes();
        etf_pkg::t_mode m;
        for (int k = int'(etf_pkg::MODE_MANDELBAR); k <= int'(etf_pkg::MODE_BURNING); k++) begin
            m = etf_pkg::t_mode'(k);
            program_window(m, 16'd64, -2 * FX_ONE, -2 * FX_ONE,
                           etf_pkg::STEP_RESET64[etf_pkg::STEP_BITS-1:0],
                           etf_pkg::STEP_RESET64[etf_pkg::STEP_BITS-1:0],
                           -32'sd53687091, 32'sd10468982);
            send_pixel(12'd512, 12'd512);
            send_pixel(12'd300, 12'd700);
            send_pixel(12'd600, 12'd400);
        end
    endtask

    task automatic test_saturation();
        program_window(etf_pkg::MODE_BURNING, 16'd64, 32'sh7fffffff, 32'sh80000000,
                       31'h7fffffff, 31'h7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        program_window(etf_pkg::MODE_JULIA, 16'hffff, 32'sh7fffffff, 32'sh80000000,
                       '0, '0, 32'sh80000000, 32'sh7fffffff);
        send_pixel(12'd0, 12'd0);
    endtask

    // c = 0 never escapes, so the count runs to the widest limit
    task automatic test_longest_limit();
        program_window(etf_pkg::MODE_MANDELBROT, 16'hffff, '0, '0, '0, '0, '0, '0);
        send_pixel(12'd0, 12'd0);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int w = 0; w < 4; w++) begin
            random_window(w == 3);
            repeat (25) begin
                send_pixel(etf_pkg::COORD_BITS'($urandom_range(4095)),
                           etf_pkg::COORD_BITS'($urandom_range(4095)));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_window();
        test_special_cases();
        test_modes();
        test_saturation();
        test_longest_limit();
        test_random_phase(0, 0);
        test_random_phase(77, 0);
        test_random_phase(0, 77);
        test_random_phase(21, 21);
        wait_for_counts();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_counts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
